@@ rtl/core/ledit_pkg.sv @@
// Shared types and constants for the line editor with echo.
package ledit_pkg;

  localparam int BUFFER_DEPTH = 64;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

endpackage

@@ rtl/core/line_editor_with_echo_top.sv @@
// Line editor with echo: top level, line buffer, echo and status output.
//
// Input channel (in_valid/in_ready): kind, rx_byte, read_index. Kind 0 is a
// received character, kind 1 clears the ready flag, kind 2 reads one entry
// of the line buffer, kind 3 does nothing.
// Output channel (out_valid/out_ready): echo_valid, echo_byte, last,
// command_ready, line_length, read_data. An erase that removes a character
// gives three transfers (backspace, space, backspace); every other input
// gives exactly one, with last set on the final transfer.
// The first result is registered and appears in the cycle after the input
// transfer. An input is taken whenever the result register is empty or its
// final transfer leaves in the same cycle, so single-result inputs flow at
// one per cycle while the receiver takes each result, and an erase holds the
// output for its three transfers. The line buffer is a one-write, one-read
// memory with registered read; a flop per entry marks it written since the
// last terminator, and a clear entry reads as zero. Reset empties the line,
// drops the flag and clears the marks. While the receiver stalls, the result
// holds and no further input is taken.
module line_editor_with_echo_top #(
  parameter int BUFFER_DEPTH = ledit_pkg::BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] rx_byte,
  input  logic [5:0] read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_byte,
  output logic       last,
  output logic       command_ready,
  output logic [5:0] line_length,
  output logic [7:0] read_data
);

  localparam int AW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [1:0] PH_LAST = 2'd2;

  logic [7:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] filled;
  logic [AW-1:0]           write_index;
  logic [AW-1:0]           write_index_next;
  logic                    ready_flag;
  logic                    ready_flag_next;

  logic                    erase_q;
  logic [1:0]              phase;
  logic                    ev_q;
  logic [7:0]              byte_q;
  logic                    rd_hit_q;
  logic [7:0]              rd_q;

  logic                    accept;
  logic                    is_rx;
  logic                    is_erase_ch;
  logic                    is_end_ch;
  logic                    line_empty;
  logic                    room;
  logic                    mem_we;
  logic                    do_erase;
  logic                    do_end;
  logic [AW-1:0]           wi_inc;
  logic [8:0]              ridx_ext;
  logic                    rd_in_range;
  logic [AW-1:0]           rd_addr;

  assign in_ready    = !out_valid || (out_ready && last);
  assign accept      = in_valid && in_ready;

  assign is_rx       = (kind == ledit_pkg::KIND_RX);
  assign is_erase_ch = (rx_byte == ledit_pkg::CH_BS) || (rx_byte == ledit_pkg::CH_DEL);
  assign is_end_ch   = (rx_byte == ledit_pkg::CH_CR) || (rx_byte == ledit_pkg::CH_LF);
  assign line_empty  = (write_index == '0);
  assign room        = (write_index < AW'(BUFFER_DEPTH - 1));
  assign wi_inc      = write_index + AW'(1);

  assign do_erase    = is_rx && is_erase_ch && !line_empty;
  assign do_end      = is_rx && is_end_ch && !line_empty;
  assign mem_we      = accept && is_rx && !is_erase_ch && !is_end_ch && room;

  assign ridx_ext    = 9'(read_index);
  assign rd_in_range = (ridx_ext < 9'(BUFFER_DEPTH));
  assign rd_addr     = ridx_ext[AW-1:0];

  always_comb begin
    write_index_next = write_index;
    ready_flag_next  = ready_flag;
    if (accept) begin
      if (do_erase) begin
        write_index_next = write_index - AW'(1);
      end else if (do_end) begin
        write_index_next = '0;
        ready_flag_next  = 1'b1;
      end else if (mem_we) begin
        write_index_next = wi_inc;
      end
      if (kind == ledit_pkg::KIND_CLEAR) begin
        ready_flag_next = 1'b0;
      end
    end
  end

  // line state and entry marks; a clear mark stands for a terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      ready_flag  <= 1'b0;
      filled      <= '0;
    end else begin
      write_index <= write_index_next;
      ready_flag  <= ready_flag_next;
      if (accept) begin
        if (mem_we) begin
          filled[write_index] <= 1'b1;
          filled[wi_inc]      <= 1'b0;
        end else if (do_end) begin
          filled[write_index] <= 1'b0;
        end else if (kind == ledit_pkg::KIND_CLEAR) begin
          filled[0] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (last) begin
          out_valid <= 1'b0;
        end else begin
          phase <= phase + 2'd1;
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
        phase     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      erase_q  <= do_erase;
      ev_q     <= is_rx && !is_end_ch && (!is_erase_ch || !line_empty);
      byte_q   <= (is_rx && !is_erase_ch && !is_end_ch) ? rx_byte : ledit_pkg::CH_NUL;
      rd_hit_q <= (kind == ledit_pkg::KIND_READ) && rd_in_range && filled[rd_addr];
    end
  end

  always_comb begin
    echo_valid = ev_q;
    last       = !erase_q || (phase == PH_LAST);
    if (erase_q) begin
      echo_byte = (phase == 2'd1) ? ledit_pkg::CH_SP : ledit_pkg::CH_BS;
    end else begin
      echo_byte = byte_q;
    end
  end

  assign command_ready = ready_flag;
  assign line_length   = 6'(write_index);
  assign read_data     = rd_hit_q ? rd_q : ledit_pkg::CH_NUL;

`ifndef SYNTHESIS
  a_erase_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && erase_q)
    else $error("erase sequence cut short");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= AW'(BUFFER_DEPTH - 1))
    else $error("write index beyond buffer");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !echo_valid |-> echo_byte == ledit_pkg::CH_NUL)
    else $error("echo byte without echo");

  a_read_no_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != ledit_pkg::CH_NUL |-> !echo_valid && last)
    else $error("read data on an echo result");

  a_state_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_ready |=> $stable(write_index) && $stable(ready_flag))
    else $error("line state moved during stall");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the line editor with echo: random typed lines, erases, reads, stalls.
module testbench;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [5:0] idx;
  } keystroke_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       last;
    logic       command_ready;
    logic [5:0] line_length;
    logic [7:0] read_data;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = ledit_pkg::KIND_RX;
  logic [7:0] rx_byte = 8'h00;
  logic [5:0] read_index = 6'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       last;
  logic       command_ready;
  logic [5:0] line_length;
  logic [7:0] read_data;

  keystroke_t typed[$];
  reply_t     terminal_replies[$];

  logic [7:0] line_mem[0:ledit_pkg::BUFFER_DEPTH-1];
  int         cursor = 0;
  logic       cmd_flag = 1'b0;

  int   total_items = 0;
  int   items_taken = 0;
  int   quiet_cycles = 0;
  int   reports = 0;
  bit   failed = 1'b0;
  bit   in_taken = 1'b0;
  bit   out_taken;
  reply_t want;
  keystroke_t nxt;

  int   gap_left = 0;
  int   send_phase = 0;
  bit   send_calm = 1'b0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   recv_phase = 0;
  bit   recv_calm = 1'b0;
  bit   squeezed = 1'b0;

  line_editor_with_echo_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .echo_valid   (echo_valid),
    .echo_byte    (echo_byte),
    .last         (last),
    .command_ready(command_ready),
    .line_length  (line_length),
    .read_data    (read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ledit_pkg::BUFFER_DEPTH; i++) line_mem[i] = ledit_pkg::CH_NUL;
  end

  function automatic void queue_key(logic [1:0] k, logic [7:0] ch, logic [5:0] idx);
    keystroke_t s;
    s.kind = k;
    s.ch   = ch;
    s.idx  = idx;
    typed.push_back(s);
  endfunction

  function automatic void add_reply(logic ev, logic [7:0] eb, logic lst, logic [7:0] rd);
    reply_t r;
    r.echo_valid    = ev;
    r.echo_byte     = eb;
    r.last          = lst;
    r.command_ready = cmd_flag;
    r.line_length   = cursor[5:0];
    r.read_data     = rd;
    terminal_replies.push_back(r);
  endfunction

  // Edits the shadow line and queues the terminal output that the keystroke causes.
  function automatic void apply_to_line(logic [1:0] k, logic [7:0] ch, logic [5:0] idx);
    logic [7:0] rd;
    rd = ledit_pkg::CH_NUL;
    case (k)
      ledit_pkg::KIND_RX: begin
        if (ch == ledit_pkg::CH_BS || ch == ledit_pkg::CH_DEL) begin
          if (cursor != 0) begin
            cursor--;
            add_reply(1'b1, ledit_pkg::CH_BS, 1'b0, ledit_pkg::CH_NUL);
            add_reply(1'b1, ledit_pkg::CH_SP, 1'b0, ledit_pkg::CH_NUL);
            add_reply(1'b1, ledit_pkg::CH_BS, 1'b1, ledit_pkg::CH_NUL);
          end else begin
            add_reply(1'b0, ledit_pkg::CH_NUL, 1'b1, ledit_pkg::CH_NUL);
          end
        end else if (ch == ledit_pkg::CH_CR || ch == ledit_pkg::CH_LF) begin
          if (cursor != 0) begin
            line_mem[cursor] = ledit_pkg::CH_NUL;
            cursor = 0;
            cmd_flag = 1'b1;
          end
          add_reply(1'b0, ledit_pkg::CH_NUL, 1'b1, ledit_pkg::CH_NUL);
        end else begin
          if (cursor < ledit_pkg::BUFFER_DEPTH - 1) begin
            line_mem[cursor] = ch;
            cursor++;
            line_mem[cursor] = ledit_pkg::CH_NUL;
          end
          add_reply(1'b1, ch, 1'b1, ledit_pkg::CH_NUL);
        end
      end
      ledit_pkg::KIND_CLEAR: begin
        cmd_flag = 1'b0;
        line_mem[0] = ledit_pkg::CH_NUL;
        add_reply(1'b0, ledit_pkg::CH_NUL, 1'b1, ledit_pkg::CH_NUL);
      end
      ledit_pkg::KIND_READ: begin
        if (idx < ledit_pkg::BUFFER_DEPTH) rd = line_mem[idx];
        add_reply(1'b0, ledit_pkg::CH_NUL, 1'b1, rd);
      end
      default: begin
        add_reply(1'b0, ledit_pkg::CH_NUL, 1'b1, ledit_pkg::CH_NUL);
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      failed = 1'b1;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, act_v);
      end
    end
  endtask

  // Monitor: output transfers checked first, as they belong to older keystrokes.
  always @(posedge clk) begin
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (terminal_replies.size() == 0) begin
          failed = 1'b1;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected transfer, expected none, actual echo %02h", $time,
                     echo_byte);
          end
        end else begin
          want = terminal_replies.pop_front();
          check_field("echo_valid", 8'(want.echo_valid), 8'(echo_valid));
          check_field("echo_byte", want.echo_byte, echo_byte);
          check_field("last", 8'(want.last), 8'(last));
          check_field("command_ready", 8'(want.command_ready), 8'(command_ready));
          check_field("line_length", 8'(want.line_length), 8'(line_length));
          check_field("read_data", want.read_data, read_data);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        apply_to_line(kind, rx_byte, read_index);
        items_taken++;
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Driver
  always @(negedge clk) begin
    if (send_phase == 0) begin
      send_phase = $urandom_range(20, 80);
      send_calm  = ($urandom_range(0, 2) == 0);
    end else begin
      send_phase--;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (typed.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!send_calm && items_taken < total_items - 40 &&
                 $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 9);
      in_valid <= 1'b0;
    end else begin
      nxt = typed.pop_front();
      kind       <= nxt.kind;
      rx_byte    <= nxt.ch;
      read_index <= nxt.idx;
      in_valid   <= 1'b1;
    end
  end

  // Receiver, with one long hold-off so the input backs up
  always @(negedge clk) begin
    if (recv_phase == 0) begin
      recv_phase = $urandom_range(20, 80);
      recv_calm  = ($urandom_range(0, 2) == 0);
    end else begin
      recv_phase--;
    end
    if (!squeezed && items_taken >= 120) begin
      squeezed  = 1'b1;
      hold_left = SQUEEZE_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!recv_calm && items_taken < total_items - 40 &&
                 $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int len;
    int n;
    logic [7:0] c;

    queue_key(ledit_pkg::KIND_READ, 8'h00, 6'd0);
    queue_key(ledit_pkg::KIND_READ, 8'hFF, 6'd63);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_BS, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_DEL, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_CR, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_LF, 6'd0);
    queue_key(KIND_NONE, 8'hFF, 6'd63);
    queue_key(ledit_pkg::KIND_RX, 8'h00, 6'd0);
    queue_key(ledit_pkg::KIND_RX, 8'hFF, 6'd63);
    queue_key(ledit_pkg::KIND_RX, 8'h41, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_BS, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_DEL, 6'd0);
    queue_key(ledit_pkg::KIND_RX, 8'h55, 6'd0);
    queue_key(ledit_pkg::KIND_RX, 8'hAA, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_CR, 6'd0);
    queue_key(ledit_pkg::KIND_READ, 8'h00, 6'd0);
    queue_key(ledit_pkg::KIND_READ, 8'h00, 6'd1);
    queue_key(ledit_pkg::KIND_READ, 8'h00, 6'd2);
    queue_key(ledit_pkg::KIND_CLEAR, 8'hFF, 6'd63);
    queue_key(ledit_pkg::KIND_READ, 8'h00, 6'd0);
    queue_key(ledit_pkg::KIND_RX, 8'h78, 6'd0);
    queue_key(ledit_pkg::KIND_RX, ledit_pkg::CH_LF, 6'd0);
    queue_key(ledit_pkg::KIND_CLEAR, 8'h00, 6'd0);
    queue_key(KIND_NONE, 8'h00, 6'd0);

    // mostly whole lines with edits, mixed with a little noise
    while (typed.size() < 460) begin
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(62, 80) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            queue_key(ledit_pkg::KIND_RX,
                      $urandom_range(0, 1) ? ledit_pkg::CH_BS : ledit_pkg::CH_DEL,
                      6'($urandom));
          end else begin
            do c = 8'($urandom);
            while (c == ledit_pkg::CH_BS || c == ledit_pkg::CH_DEL ||
                   c == ledit_pkg::CH_CR || c == ledit_pkg::CH_LF);
            queue_key(ledit_pkg::KIND_RX, c, 6'($urandom));
          end
        end
        queue_key(ledit_pkg::KIND_RX,
                  $urandom_range(0, 1) ? ledit_pkg::CH_CR : ledit_pkg::CH_LF,
                  6'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) queue_key(ledit_pkg::KIND_READ, 8'($urandom),
                             6'($urandom_range(0, (len > 62) ? 63 : len + 1)));
        if ($urandom_range(0, 1) == 1) begin
          queue_key(ledit_pkg::KIND_CLEAR, 8'($urandom), 6'($urandom));
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) queue_key(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
      end
    end
    total_items = typed.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken < total_items) @(negedge clk);
    while (terminal_replies.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ledit_pkg.sv
rtl/core/line_editor_with_echo_top.sv
bench/testbench.sv
